/* rtl/rrvf_pkg.sv */
// Package with constants shared by the RR rate variability flag block.
package rrvf_pkg;

  localparam int RATE_W   = 10;
  localparam int TERM_W   = 24;
  localparam int DIVN_W   = 24;
  localparam int DIVD_W   = 18;
  localparam int DINT_W   = 17;
  localparam int OUT_W    = 80;

  localparam logic [RATE_W-1:0] RATE_MIN = 10'd1;
  localparam logic [RATE_W-1:0] RATE_MAX = 10'd1023;
  localparam logic [DIVN_W-1:0] RND_NUM  = 24'd120000;
  localparam logic [DINT_W-1:0] D_CAP    = 17'd120001;
  localparam logic [DIVN_W-1:0] SPAN_NUM = 24'd15360000;
  localparam logic [4:0]        DIV_LAST = 5'd23;

  localparam logic [4:0] CODE_NONE   = 5'h1F;
  localparam logic [4:0] CODE_FIRST  = 5'd2;
  localparam logic [4:0] CODE_SECOND = 5'd5;
  localparam logic [4:0] CODE_THIRD  = 5'd12;

  localparam logic [7:0] THR_RESET = 8'd30;

endpackage

/* rtl/rr_rate_variability_flag.sv */
// Top level: RR interval rate window with trimmed spread test and span report.
// A non-positive or first peak is answered straight from idle; while the window fills a peak takes
// two 24-step passes of the shared restoring divider and one memory write, and once it is full
// also the window scan (S_SCAN), the trim (S_TRIM) and the spread test (S_VAR1, S_VAR2, S_DONE).
// Throughput: one peak in flight; the next transfer is taken as the result leaves.
// Synchronous active-low reset clears history, fill count and threshold; memory is not reset.
module rr_rate_variability_flag #(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] peak_time_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] mark_valid, [32:1] start_time_ms, [64:33] end_time_ms, [69:65] mark_type,
  // [74:70] mark_code_second, [79:75] mark_code_third
  output logic [rrvf_pkg::OUT_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rrvf_pkg::*;

  localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int M_CNT = WINDOW - 4;
  localparam int MW    = $clog2(M_CNT + 1);
  localparam int SXW   = $clog2(WINDOW * 1023 + 1);
  localparam int SXXW  = $clog2(WINDOW * 1046529 + 1);
  localparam int SPW   = $clog2(WINDOW * 15360000 + 1);
  localparam int PAW   = 2 * SXW;
  localparam int PBW   = SXXW + MW;
  localparam int DW    = (PAW > PBW) ? PAW : PBW;
  localparam int TMW   = 8 + MW;
  localparam int RHW   = 2 * TMW;
  localparam int MEMW  = RATE_W + TERM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVR, S_DIVS, S_WR, S_SCAN, S_TRIM, S_VAR1, S_VAR2, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0] thr_r;
  logic signed [31:0] prev_r, prev_nxt;
  logic have_r, have_nxt;
  logic [IW-1:0] fill_r, fill_nxt, wptr_r, wptr_nxt;
  logic [31:0] peak_r, peak_nxt;
  logic [DIVN_W-1:0] num_r, num_nxt;
  logic [DIVD_W-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic rdv_r, rdv_nxt;
  logic [MEMW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic [SXW-1:0] sx_r, sx_nxt;
  logic [SXXW-1:0] sxx_r, sxx_nxt;
  logic [SPW-1:0] span_r, span_nxt;
  logic [RATE_W-1:0] max1_r, max1_nxt, max2_r, max2_nxt;
  logic [RATE_W-1:0] min1_r, min1_nxt, min2_r, min2_nxt;
  logic [1:0] tk_r, tk_nxt;
  logic [PAW-1:0] pa_r, pa_nxt;
  logic [PBW-1:0] pb_r, pb_nxt;
  logic [TMW-1:0] tm_r, tm_nxt;
  logic [DW-1:0] diff_r, diff_nxt;
  logic [RHW-1:0] rhs_r, rhs_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [MEMW-1:0] mem [WINDOW];

  logic signed [31:0] in_peak;
  logic signed [32:0] ivl;
  logic [DINT_W-1:0] dint;
  logic [DIVD_W:0] rem_sh;
  logic div_ge;
  logic [DIVN_W-1:0] quo;
  logic [RATE_W-1:0] x, tv;
  logic [2*RATE_W-1:0] xsq, tvsq;
  logic wr_en, flag;
  logic [31:0] start_t;
  logic cfg_wr;

  localparam logic [OUT_W-1:0] NO_MARK = {CODE_NONE, CODE_NONE, CODE_NONE,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {24'd0, thr_r} : 32'd0;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_peak = in_tdata;
  assign ivl     = {in_peak[31], in_peak} - {prev_r[31], prev_r};
  always_comb begin
    if (ivl < 33'sd1) begin
      dint = DINT_W'(1);
    end else if (ivl > 33'sd120000) begin
      dint = D_CAP;
    end else begin
      dint = ivl[DINT_W-1:0];
    end
  end

  assign rem_sh = {rem_r, num_r[DIVN_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};
  assign quo    = {num_r[DIVN_W-2:0], div_ge};

  assign x    = rd_data_r[MEMW-1:TERM_W];
  assign xsq  = (2*RATE_W)'(x) * (2*RATE_W)'(x);
  always_comb begin
    case (tk_r)
      2'd0:    tv = max1_r;
      2'd1:    tv = max2_r;
      2'd2:    tv = min1_r;
      default: tv = min2_r;
    endcase
  end
  assign tvsq    = (2*RATE_W)'(tv) * (2*RATE_W)'(tv);
  assign wr_en   = (state_r == S_WR);
  assign rd_addr = (scnt_r < CW'(WINDOW)) ? scnt_r[IW-1:0] : '0;
  assign flag    = (64'(diff_r) << 4) > 64'(rhs_r);
  assign start_t = peak_r - 32'(span_r >> 8);

  always_comb begin
    state_nxt = state_r; prev_nxt = prev_r; have_nxt = have_r;
    fill_nxt = fill_r; wptr_nxt = wptr_r; peak_nxt = peak_r;
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r;
    rate_nxt = rate_r; term_nxt = term_r; scnt_nxt = scnt_r; rdv_nxt = rdv_r;
    sx_nxt = sx_r; sxx_nxt = sxx_r; span_nxt = span_r;
    max1_nxt = max1_r; max2_nxt = max2_r; min1_nxt = min1_r; min2_nxt = min2_r;
    tk_nxt = tk_r; pa_nxt = pa_r; pb_nxt = pb_r; tm_nxt = tm_r;
    diff_nxt = diff_r; rhs_nxt = rhs_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_peak <= 32'sd0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = NO_MARK;
          end else if (!have_r) begin
            prev_nxt      = in_peak;
            have_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            out_data_nxt  = NO_MARK;
          end else begin
            prev_nxt  = in_peak;
            peak_nxt  = in_tdata;
            num_nxt   = RND_NUM + DIVN_W'(dint);
            den_nxt   = {dint, 1'b0};
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIVR;
          end
        end
      end
      S_DIVR, S_DIVS: begin
        num_nxt  = quo;
        rem_nxt  = div_ge ? DIVD_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIVD_W-1:0];
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == DIV_LAST) begin
          if (state_r == S_DIVR) begin
            if (quo == '0) begin
              rate_nxt = RATE_MIN;
              den_nxt  = DIVD_W'(RATE_MIN);
            end else if (quo > DIVN_W'(RATE_MAX)) begin
              rate_nxt = RATE_MAX;
              den_nxt  = DIVD_W'(RATE_MAX);
            end else begin
              rate_nxt = quo[RATE_W-1:0];
              den_nxt  = DIVD_W'(quo[RATE_W-1:0]);
            end
            num_nxt   = SPAN_NUM;
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIVS;
          end else begin
            term_nxt  = quo;
            state_nxt = S_WR;
          end
        end
      end
      S_WR: begin
        wptr_nxt = (wptr_r == IW'(WINDOW - 1)) ? '0 : wptr_r + IW'(1);
        if (fill_r < IW'(WINDOW - 1)) begin
          fill_nxt      = fill_r + IW'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = NO_MARK;
          state_nxt     = S_IDLE;
        end else begin
          scnt_nxt  = '0;
          rdv_nxt   = 1'b0;
          sx_nxt    = '0;
          sxx_nxt   = '0;
          span_nxt  = '0;
          max1_nxt  = '0;
          max2_nxt  = '0;
          min1_nxt  = RATE_MAX;
          min2_nxt  = RATE_MAX;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scnt_r < CW'(WINDOW)) begin
          scnt_nxt = scnt_r + CW'(1);
          rdv_nxt  = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        if (rdv_r) begin
          sx_nxt   = sx_r + SXW'(x);
          sxx_nxt  = sxx_r + SXXW'(xsq);
          span_nxt = span_r + SPW'(rd_data_r[TERM_W-1:0]);
          if (x > max1_r) begin
            max1_nxt = x;
            max2_nxt = max1_r;
          end else if (x > max2_r) begin
            max2_nxt = x;
          end
          if (x < min1_r) begin
            min1_nxt = x;
            min2_nxt = min1_r;
          end else if (x < min2_r) begin
            min2_nxt = x;
          end
          if (scnt_r == CW'(WINDOW)) begin
            tk_nxt    = '0;
            state_nxt = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        sx_nxt  = sx_r - SXW'(tv);
        sxx_nxt = sxx_r - SXXW'(tvsq);
        tk_nxt  = tk_r + 2'd1;
        if (tk_r == 2'd3) begin
          state_nxt = S_VAR1;
        end
      end
      S_VAR1: begin
        pa_nxt    = PAW'(sx_r) * PAW'(sx_r);
        pb_nxt    = PBW'(M_CNT) * PBW'(sxx_r);
        tm_nxt    = TMW'(thr_r) * TMW'(M_CNT);
        state_nxt = S_VAR2;
      end
      S_VAR2: begin
        diff_nxt  = DW'(pb_r) - DW'(pa_r);
        rhs_nxt   = RHW'(tm_r) * RHW'(tm_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = flag ? {CODE_THIRD, CODE_SECOND, CODE_FIRST, peak_r, start_t, 1'b1}
                               : NO_MARK;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= {rate_r, term_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      prev_r      <= '0;
      have_r      <= 1'b0;
      fill_r      <= '0;
      wptr_r      <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == 1'b0) begin
        thr_r <= cfg_pwdata[7:0];
      end
      prev_r      <= prev_nxt;
      have_r      <= have_nxt;
      fill_r      <= fill_nxt;
      wptr_r      <= wptr_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    peak_r     <= peak_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    rate_r     <= rate_nxt;
    term_r     <= term_nxt;
    scnt_r     <= scnt_nxt;
    sx_r       <= sx_nxt;
    sxx_r      <= sxx_nxt;
    span_r     <= span_nxt;
    max1_r     <= max1_nxt;
    max2_r     <= max2_nxt;
    min1_r     <= min1_nxt;
    min2_r     <= min2_nxt;
    tk_r       <= tk_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    tm_r       <= tm_nxt;
    diff_r     <= diff_nxt;
    rhs_r      <= rhs_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= IW'(WINDOW - 1))
    else $error("fill count past window");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");

  a_mark_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && fill_r == IW'(WINDOW - 1)))
    else $error("mark result without full window");

endmodule

/* tb/tb_top.sv */
// Testbench for rr_rate_variability_flag: scoreboard class, stream drivers and run control.
`timescale 1ns / 100ps

class rr_flag_scoreboard;
  typedef struct packed {
    logic [4:0]  code3;
    logic [4:0]  code2;
    logic [4:0]  code1;
    logic [31:0] end_ms;
    logic [31:0] start_ms;
    logic        flag;
  } mark_t;

  localparam int WIN = 16;

  logic [7:0]  thr;
  longint      prev_ms;
  bit          have_prev;
  int          fill;
  logic [9:0]  rates [WIN];
  mark_t       marks_due [$];
  int          errors;
  int          flags_seen;
  int          results_seen;

  function new();
    thr = rrvf_pkg::THR_RESET;
    prev_ms = 0;
    have_prev = 0;
    fill = 0;
    errors = 0;
    flags_seen = 0;
    results_seen = 0;
  endfunction

  function logic [9:0] rate_of(longint iv);
    longint r;
    if (iv < 1) iv = 1;
    r = (120000 + iv) / (2 * iv);
    if (r < 1) r = 1;
    if (r > 1023) r = 1023;
    return r[9:0];
  endfunction

  function void note_peak(logic [31:0] raw);
    mark_t m;
    longint peak;
    bit gone [WIN];
    int hi, lo;
    longint unsigned sx, sxx, span, lhs, rhs;
    longint start_ms;
    m = '{flag: 1'b0, start_ms: 32'hFFFFFFFF, end_ms: 32'hFFFFFFFF,
          code1: rrvf_pkg::CODE_NONE, code2: rrvf_pkg::CODE_NONE,
          code3: rrvf_pkg::CODE_NONE};
    peak = longint'($signed(raw));
    if (peak > 0) begin
      if (!have_prev) begin
        prev_ms = peak;
        have_prev = 1;
      end else begin
        if (fill < WIN) rates[fill] = rate_of(peak - prev_ms);
        prev_ms = peak;
        fill++;
        if (fill >= WIN) begin
          foreach (gone[i]) gone[i] = 0;
          for (int p = 0; p < 2; p++) begin
            hi = -1;
            for (int i = 0; i < WIN; i++)
              if (!gone[i] && (hi < 0 || rates[i] > rates[hi])) hi = i;
            gone[hi] = 1;
            lo = -1;
            for (int i = 0; i < WIN; i++)
              if (!gone[i] && (lo < 0 || rates[i] < rates[lo])) lo = i;
            gone[lo] = 1;
          end
          sx = 0; sxx = 0; span = 0;
          for (int i = 0; i < WIN; i++) begin
            if (!gone[i]) begin
              sx += rates[i];
              sxx += rates[i] * rates[i];
            end
            span += 64'd15360000 / rates[i];
          end
          lhs = 16 * (12 * sxx - sx * sx);
          rhs = thr * thr * 144;
          start_ms = peak - longint'(span >> 8);
          for (int i = 1; i < WIN; i++) rates[i-1] = rates[i];
          fill = WIN - 1;
          if (lhs > rhs)
            m = '{flag: 1'b1, start_ms: start_ms[31:0], end_ms: raw,
                  code1: rrvf_pkg::CODE_FIRST, code2: rrvf_pkg::CODE_SECOND,
                  code3: rrvf_pkg::CODE_THIRD};
        end
      end
    end
    marks_due = {marks_due, m};
  endfunction

  function void check_mark(logic [79:0] d);
    mark_t e;
    mark_t a;
    a = d;
    results_seen++;
    if (marks_due.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    e = marks_due.pop_front();
    if (a.flag) flags_seen++;
    if (a.flag !== e.flag) begin
      $error("mark_valid exp %0d got %0d", e.flag, a.flag); errors++;
    end
    if (a.start_ms !== e.start_ms) begin
      $error("start_time_ms exp %0d got %0d", $signed(e.start_ms), $signed(a.start_ms));
      errors++;
    end
    if (a.end_ms !== e.end_ms) begin
      $error("end_time_ms exp %0d got %0d", $signed(e.end_ms), $signed(a.end_ms)); errors++;
    end
    if (a.code1 !== e.code1) begin
      $error("mark_type exp %0d got %0d", e.code1, a.code1); errors++;
    end
    if (a.code2 !== e.code2) begin
      $error("mark_code_second exp %0d got %0d", e.code2, a.code2); errors++;
    end
    if (a.code3 !== e.code3) begin
      $error("mark_code_third exp %0d got %0d", e.code3, a.code3); errors++;
    end
  endfunction
endclass

module tb_top;
  import rrvf_pkg::*;

  localparam int LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rr_flag_scoreboard sb;
  int     idle_pct;
  int     stall_pct;
  int     cycles;
  longint t_ms;
  bit     irregular;
  int     peaks_sent;

  rr_rate_variability_flag dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    peaks_sent = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_peak(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_mark(out_tdata);
  end

  task automatic send_peak(input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    peaks_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.marks_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_thr(input logic [7:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.thr = v;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] next_peak();
    int r;
    longint iv;
    r = $urandom_range(99);
    if (r < 4) begin
      iv = $urandom;
      if (iv[31] == 1'b0 && iv != 0) t_ms = iv[31:0];
      return iv[31:0];
    end
    if (r < 7) return (r == 4) ? 32'd0 : (32'h80000000 | $urandom);
    if ($urandom_range(29) == 0) irregular = !irregular;
    iv = irregular ? $urandom_range(2500, 250) : 780 + $urandom_range(40);
    if ($urandom_range(99) == 0) iv = $urandom_range(300000, 100000);
    if (t_ms + iv > 64'sh7FFFFFFF) t_ms = $urandom_range(1000, 1);
    else t_ms = t_ms + iv;
    return t_ms[31:0];
  endfunction

  initial begin
    logic [7:0] thr_set [4];
    thr_set = '{8'd0, 8'd255, 8'd30, 8'd8};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_thr(THR_RESET);
    send_peak(32'd0);
    send_peak(32'hFFFFFFFF);
    send_peak(32'h80000000);
    send_peak(32'd1000);
    for (int i = 1; i <= 16; i++) send_peak(32'd1000 + 800 * i);
    send_peak(32'd13800);
    send_peak(32'd313800);
    send_peak(32'h7FFFFFFF);
    send_peak(32'd5000);
    t_ms = 5000;
    irregular = 0;
    drain();

    for (int p = 0; p < 4; p++) begin
      write_thr(p == 3 ? 8'($urandom_range(255)) : thr_set[p]);
      idle_pct = (p == 0) ? 26 : (p == 1) ? 87 : 0;
      stall_pct = (p == 0) ? 87 : (p == 1) ? 26 : 0;
      for (int i = 0; i < 135; i++) begin
        if (p == 1 && i == 60) drain();
        send_peak(next_peak());
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d peaks over four threshold settings; %0d results, %0d flagged.",
             peaks_sent, sb.results_seen, sb.flags_seen);
    if (sb.errors == 0 && sb.marks_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
